FILE: rtl/pnf_pkg.sv
// Package for the 2D fBm gradient-noise block: constants, types and helpers.
package pnf_pkg;

  localparam int TableEntries = 256;
  localparam int IdxW         = $clog2(TableEntries);
  localparam int MaxOctaves   = 8;
  localparam int OctW         = $clog2(MaxOctaves);
  localparam int QOne         = 65536;
  localparam int CoreDepth    = 10;

  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_EVAL = 1'b1;

  localparam logic [0:0] REG_OCTAVE_COUNT = 1'b0;

  // Octave work item travelling down the core.
  typedef struct packed {
    logic                   last;
    logic [OctW-1:0]        oct;
    logic [16:0]            xf;
    logic [16:0]            yf;
    logic [IdxW-1:0]        x0;
    logic [IdxW-1:0]        y0;
  } oct_item_t;

  // Q16.16 product rounded to nearest, ties up (floor of p + half).
  function automatic logic signed [47:0] qround(input logic signed [63:0] p);
    logic signed [63:0] s;
    s = p + 64'sd32768;
    return s[63:16];
  endfunction

  // Rounded Q16.16 product of two 32-bit operands.
  function automatic logic signed [47:0] qmul(input logic signed [31:0] a,
                                              input logic signed [31:0] b);
    logic signed [63:0] p;
    p = 64'(a) * 64'(b);
    return qround(p);
  endfunction

  // Gradient dot product for hash code k.
  function automatic logic signed [18:0] grad(input logic [2:0] k,
                                              input logic signed [17:0] dx,
                                              input logic signed [17:0] dy);
    logic signed [18:0] ex, ey, r;
    ex = 19'(dx);
    ey = 19'(dy);
    case (k)
      3'd0:    r = ex;
      3'd1:    r = -ex;
      3'd2:    r = ey;
      3'd3:    r = -ey;
      3'd4:    r = ex + ey;
      3'd5:    r = -ex + ey;
      3'd6:    r = ex - ey;
      default: r = -ex - ey;
    endcase
    return r;
  endfunction

endpackage

FILE: rtl/pnf_core.sv
// Pipelined per-octave noise core: table hashing, fade, gradients, lerps, weighting.
module pnf_core (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     adv_i,
  input  logic                     in_valid_i,
  input  pnf_pkg::oct_item_t       in_item_i,
  input  logic                     wr_en_i,
  input  logic [pnf_pkg::IdxW-1:0] wr_addr_i,
  input  logic [7:0]               wr_data_i,
  output logic                     out_valid_o,
  output logic                     out_last_o,
  output logic [31:0]              out_term_o
);
  // three copies so each copy is read at two addresses per cycle
  logic [7:0] mem_a_q [pnf_pkg::TableEntries];
  logic [7:0] mem_b_q [pnf_pkg::TableEntries];
  logic [7:0] mem_c_q [pnf_pkg::TableEntries];

  logic [pnf_pkg::CoreDepth-1:0] vld_q;
  pnf_pkg::oct_item_t it_q [pnf_pkg::CoreDepth];

  // fade pipelines for u (x) and v (y)
  logic signed [47:0] fu_q [5];
  logic signed [47:0] fv_q [5];

  logic [7:0] px0_q, px1_q;
  logic [7:0] aa_q, ab_q, ba_q, bb_q;
  logic signed [18:0] ga_q, gb_q, gc_q, gd_q;
  logic signed [47:0] tl_q, bl_q, tlh_q, blh_q, pt_q, pb_q, tla_q, bla_q;
  logic signed [47:0] top_q, bot_q, toph_q, pr_q, res_q, fin_q;
  logic signed [47:0] vh_q [2];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_a_q[wr_addr_i] <= wr_data_i;
      mem_b_q[wr_addr_i] <= wr_data_i;
      mem_c_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv_i) begin
      vld_q <= {vld_q[pnf_pkg::CoreDepth-2:0], in_valid_i};
    end
  end

  logic [pnf_pkg::IdxW-1:0] x1, y1;
  always_comb begin
    x1 = it_q[0].x0 + 1'b1;
    y1 = it_q[1].y0 + 1'b1;
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      it_q[0] <= in_item_i;
      for (int s = 1; s < pnf_pkg::CoreDepth; s++) it_q[s] <= it_q[s-1];
      // stage 1: first-level hashes
      px0_q <= mem_a_q[it_q[0].x0];
      px1_q <= mem_b_q[x1];
      // stage 2: corner hashes
      aa_q <= mem_a_q[px0_q[pnf_pkg::IdxW-1:0] + it_q[1].y0];
      ab_q <= mem_b_q[px0_q[pnf_pkg::IdxW-1:0] + y1];
      ba_q <= mem_c_q[px1_q[pnf_pkg::IdxW-1:0] + it_q[1].y0];
      bb_q <= mem_c_q[px1_q[pnf_pkg::IdxW-1:0] + y1];
      // stage 3: gradients
      ga_q <= pnf_pkg::grad(aa_q[2:0], 18'(it_q[2].xf), 18'(it_q[2].yf));
      gb_q <= pnf_pkg::grad(ba_q[2:0], 18'(it_q[2].xf) - 18'(pnf_pkg::QOne),
                            18'(it_q[2].yf));
      gc_q <= pnf_pkg::grad(ab_q[2:0], 18'(it_q[2].xf),
                            18'(it_q[2].yf) - 18'(pnf_pkg::QOne));
      gd_q <= pnf_pkg::grad(bb_q[2:0], 18'(it_q[2].xf) - 18'(pnf_pkg::QOne),
                            18'(it_q[2].yf) - 18'(pnf_pkg::QOne));
      // fade chain, one product per stage: stages 0..4
      fu_q[0] <= 48'(6 * $signed({1'b0, in_item_i.xf})) - 48'(15 * pnf_pkg::QOne);
      fv_q[0] <= 48'(6 * $signed({1'b0, in_item_i.yf})) - 48'(15 * pnf_pkg::QOne);
      fu_q[1] <= pnf_pkg::qmul(32'(fu_q[0]), 32'(it_q[0].xf)) + 48'(10 * pnf_pkg::QOne);
      fv_q[1] <= pnf_pkg::qmul(32'(fv_q[0]), 32'(it_q[0].yf)) + 48'(10 * pnf_pkg::QOne);
      for (int s = 2; s < 5; s++) begin
        fu_q[s] <= pnf_pkg::qmul(32'(fu_q[s-1]), 32'(it_q[s-1].xf));
        fv_q[s] <= pnf_pkg::qmul(32'(fv_q[s-1]), 32'(it_q[s-1].yf));
      end
      // stage 4: lerp deltas
      tl_q  <= 48'(gb_q) - 48'(ga_q);
      bl_q  <= 48'(gd_q) - 48'(gc_q);
      tlh_q <= 48'(ga_q);
      blh_q <= 48'(gc_q);
      // stage 5: x lerp products
      pt_q  <= pnf_pkg::qmul(32'(fu_q[4]), 32'(tl_q));
      pb_q  <= pnf_pkg::qmul(32'(fu_q[4]), 32'(bl_q));
      tla_q <= tlh_q;
      bla_q <= blh_q;
      vh_q[0] <= fv_q[4];
      // stage 6: x lerps
      top_q <= tla_q + pt_q;
      bot_q <= bla_q + pb_q;
      vh_q[1] <= vh_q[0];
      // stage 7: y lerp product
      pr_q   <= pnf_pkg::qmul(32'(vh_q[1]), 32'(bot_q - top_q));
      toph_q <= top_q;
      // stage 8: y lerp
      res_q <= toph_q + pr_q;
      // stage 9: octave weight
      fin_q <= pnf_pkg::qround(64'(res_q) <<< (16 - it_q[pnf_pkg::CoreDepth-2].oct));
    end
  end

  assign out_valid_o = vld_q[pnf_pkg::CoreDepth-1];
  assign out_last_o  = it_q[pnf_pkg::CoreDepth-1].last;
  assign out_term_o  = fin_q[31:0];

  // a term is never emitted right after reset
  assert property (@(posedge clk_i) !rst_ni |=> !out_valid_o)
    else $error("core output valid after reset");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv_i |=> $stable(vld_q))
    else $error("pipeline moved while held");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv_i && wr_en_i) |-> !in_valid_i)
    else $error("table write during octave issue");
endmodule

FILE: rtl/perlin_noise_2d_fbm.sv
// Top level of the 2D fBm gradient-noise block: issue, accumulate, APB, output.
//  channel | direction | handshake            | payload
//  input   | in        | valid_i / stall_o    | req_type, table_index/value, x/y_coord
//  output  | out       | valid_o / stall_i    | noise_value
//  config  | in        | APB psel/penable     | octave_count
// An evaluate issues n = min(octave_count,8) octaves, one per cycle while the output
// is not held, into a 10-stage core; its result is registered when the last term
// leaves the core, and no new transaction is taken before then. Zero octaves: the
// result is valid right after the accepting edge. A load writes the table at that edge.
// Reset clears control; the permutation table is undefined until written.
// A held output stalls the whole core and the input without loss.
module perlin_noise_2d_fbm (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  output logic               stall_o,
  input  logic               req_type_i,
  input  logic [7:0]         table_index_i,
  input  logic [7:0]         table_value_i,
  input  logic signed [31:0] x_coord_i,
  input  logic signed [31:0] y_coord_i,
  output logic               valid_o,
  input  logic               stall_i,
  output logic signed [31:0] noise_value_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [1:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  logic [3:0] oct_cnt_q;
  logic       busy_q, issuing_q;
  logic [pnf_pkg::OctW:0] oct_q, n_q;
  logic signed [31:0] x_q, y_q;
  logic [31:0] acc_q;
  logic        out_v_q;
  logic [31:0] out_d_q;

  logic adv, accept;
  pnf_pkg::oct_item_t item;
  logic core_v, core_last;
  logic [31:0] core_term;
  logic [pnf_pkg::OctW:0] n_eff;
  logic signed [63:0] xs, ys;

  assign pready = 1'b1;
  assign prdata = (paddr[1:0] == {pnf_pkg::REG_OCTAVE_COUNT, 1'b0}) ?
                  {28'd0, oct_cnt_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) oct_cnt_q <= 4'd1;
    else if (psel && penable && pwrite && paddr[1] == pnf_pkg::REG_OCTAVE_COUNT)
      oct_cnt_q <= pwdata[3:0];
  end

  assign adv    = !(out_v_q && stall_i);
  assign stall_o = busy_q || !adv;
  assign accept = valid_i && !stall_o;
  assign n_eff  = (oct_cnt_q > 4'(pnf_pkg::MaxOctaves)) ?
                  (pnf_pkg::OctW+1)'(pnf_pkg::MaxOctaves) : oct_cnt_q[pnf_pkg::OctW:0];

  always_comb begin
    xs = 64'(x_q) <<< oct_q[pnf_pkg::OctW-1:0];
    ys = 64'(y_q) <<< oct_q[pnf_pkg::OctW-1:0];
    item.last = (oct_q + 1'b1 == n_q);
    item.oct  = oct_q[pnf_pkg::OctW-1:0];
    item.xf   = {1'b0, xs[15:0]};
    item.yf   = {1'b0, ys[15:0]};
    item.x0   = xs[16 +: pnf_pkg::IdxW];
    item.y0   = ys[16 +: pnf_pkg::IdxW];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; issuing_q <= 1'b0; oct_q <= '0; n_q <= '0;
      x_q <= '0; y_q <= '0; acc_q <= '0; out_v_q <= 1'b0; out_d_q <= '0;
    end else begin
      if (accept && req_type_i == pnf_pkg::REQ_EVAL) begin
        x_q <= x_coord_i; y_q <= y_coord_i;
        oct_q <= '0; n_q <= n_eff; acc_q <= '0;
        if (n_eff != '0) begin
          busy_q <= 1'b1; issuing_q <= 1'b1;
        end
      end
      if (adv && issuing_q) begin
        oct_q <= oct_q + 1'b1;
        if (item.last) issuing_q <= 1'b0;
      end
      if (adv && core_v) begin
        if (core_last) begin
          acc_q <= '0; busy_q <= 1'b0;
        end else acc_q <= acc_q + core_term;
      end
      // zero octaves answer at once; otherwise the last term closes the sum
      if (accept && req_type_i == pnf_pkg::REQ_EVAL && n_eff == '0) begin
        out_v_q <= 1'b1; out_d_q <= 32'd0;
      end else if (adv && core_v && core_last) begin
        out_v_q <= 1'b1; out_d_q <= acc_q + core_term;
      end else if (out_v_q && !stall_i) begin
        out_v_q <= 1'b0;
      end
    end
  end

  pnf_core u_core (
    .clk_i, .rst_ni, .adv_i(adv),
    .in_valid_i(issuing_q), .in_item_i(item),
    .wr_en_i(accept && req_type_i == pnf_pkg::REQ_LOAD),
    .wr_addr_i(table_index_i[pnf_pkg::IdxW-1:0]), .wr_data_i(table_value_i),
    .out_valid_o(core_v), .out_last_o(core_last), .out_term_o(core_term)
  );

  assign valid_o       = out_v_q;
  assign noise_value_o = out_d_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && stall_i) |=> valid_o)
    else $error("result dropped under stall");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    issuing_q |-> busy_q)
    else $error("issuing while idle");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> !busy_q)
    else $error("accepted item while busy");
endmodule
